/* rtl/caa_pkg.sv */
// caa_pkg: shared types, codes and constants for the controller authorisation arbiter
// no dependencies
`timescale 1ns / 1ps
package caa_pkg;

    localparam int MAX_CONTROLLERS_DEF  = 4;
    localparam int TICKS_PER_SECOND_DEF = 1000000;
    localparam int SUBTICK_W            = 20;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_SUBSCRIBE = 3'd1,
        OP_CONTROL   = 3'd2,
        OP_DISCONN   = 3'd3,
        OP_OPEN      = 3'd4,
        OP_CLOSE     = 3'd5,
        OP_FORGET    = 3'd6,
        OP_READ_PIN  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_REFUSED   = 3'd1,
        ST_NO_SLOT   = 3'd2,
        ST_SHORT     = 3'd3,
        ST_BAD_INDEX = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [47:0] peer_address;
        logic [15:0] link_id;
        logic [15:0] subscribe_word;
        logic [7:0]  write_length;
        logic [15:0] window_seconds;
        logic [3:0]  pin_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        close_link;
        logic        forward_payload;
        logic [3:0]  reply_slot;
        logic        driver_valid;
        logic [3:0]  driver_slot;
        logic        driver_ready;
        logic [31:0] driver_epoch;
        logic [4:0]  pinned_count;
        logic [16:0] window_left;
        logic        pin_added;
        logic [47:0] pin_value;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic scan;      // compare entry at scan index
        logic execute;   // apply the update
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
    } stat_t;

endpackage

/* rtl/controller_authorisation_arbiter.sv */
// controller_authorisation_arbiter: top level joining sequencer and datapath
// depends on caa_pkg, caa_ctrl, caa_datapath
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_valid / s_ready   | s_item (caa_pkg::in_item_t)
//  m_      | out       | m_valid / m_ready   | m_item (caa_pkg::out_item_t)
//
// each item is loaded, then scanned with one table entry compared per cycle, then
// applied in an update step; a new item is taken only once the block is back in idle
// synchronous active-low reset clears tables' valid bits, counters and window
// a stalled result holds in its register; the next item is taken once it drains
`timescale 1ns / 1ps
module controller_authorisation_arbiter #(
    parameter int MAX_CONTROLLERS  = caa_pkg::MAX_CONTROLLERS_DEF,
    parameter int TICKS_PER_SECOND = caa_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  caa_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output caa_pkg::out_item_t m_item
);
    caa_pkg::cmd_t  cmd;
    caa_pkg::stat_t stat;

    caa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .stat(stat)
    );

    caa_datapath #(
        .MAX_CONTROLLERS(MAX_CONTROLLERS), .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_item(s_item), .out_item(m_item)
    );
endmodule

/* rtl/caa_datapath.sv */
// caa_datapath: tables, scan matching and update logic
// depends on caa_pkg
`timescale 1ns / 1ps
module caa_datapath #(
    parameter int MAX_CONTROLLERS  = caa_pkg::MAX_CONTROLLERS_DEF,
    parameter int TICKS_PER_SECOND = caa_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  caa_pkg::cmd_t      cmd,
    output caa_pkg::stat_t     stat,
    input  caa_pkg::in_item_t  in_item,
    output caa_pkg::out_item_t out_item
);
    localparam int N  = MAX_CONTROLLERS;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = $clog2(N + 1);
    localparam logic [caa_pkg::SUBTICK_W-1:0] TPS_M1 =
        caa_pkg::SUBTICK_W'(TICKS_PER_SECOND - 1);

    caa_pkg::in_item_t item_reg;
    logic [47:0] pin_tab [N];
    logic [47:0] slot_addr [N];
    logic [15:0] slot_link [N];
    logic [N-1:0] used_reg, sub_reg;
    logic [CW-1:0] ptotal_reg;
    logic [IW-1:0] drv_slot_reg;
    logic drv_valid_reg;
    logic [31:0] epoch_reg;
    logic [16:0] wsecs_reg;
    logic [caa_pkg::SUBTICK_W-1:0] wsub_reg;
    logic [IW-1:0] scan_reg;
    // scan results
    logic pin_hit_reg, slot_hit_reg, free_found_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;
    caa_pkg::out_item_t out_reg;

    assign stat.scan_last = (scan_reg == IW'(N - 1));
    assign out_item = out_reg;

    // scan one entry a cycle
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg       <= in_item;
            scan_reg       <= '0;
            pin_hit_reg    <= 1'b0;
            slot_hit_reg   <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.scan) begin
            if (!stat.scan_last) scan_reg <= scan_reg + 1'b1;
            if (CW'(scan_reg) < ptotal_reg && pin_tab[scan_reg] == item_reg.peer_address)
                pin_hit_reg <= 1'b1;
            if (!slot_hit_reg && used_reg[scan_reg] &&
                slot_addr[scan_reg] == item_reg.peer_address) begin
                slot_hit_reg <= 1'b1;
                hit_idx_reg  <= scan_reg;
            end
            if (!free_found_reg && !used_reg[scan_reg]) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= scan_reg;
            end
        end
    end

    // update
    logic [N-1:0] used_next, sub_next;
    logic [CW-1:0] ptotal_next;
    logic [IW-1:0] drv_slot_next;
    logic drv_valid_next;
    logic [31:0] epoch_next;
    logic [16:0] wsecs_next;
    logic [caa_pkg::SUBTICK_W-1:0] wsub_next;
    logic pin_we, slot_we, slot_new;
    logic [IW-1:0] slot_idx;
    logic [2:0] st;
    logic cl, fwd, added;
    logic [3:0] reply;
    logic [47:0] pval;

    always_comb begin
        used_next = used_reg; sub_next = sub_reg; ptotal_next = ptotal_reg;
        drv_slot_next = drv_slot_reg; drv_valid_next = drv_valid_reg;
        epoch_next = epoch_reg; wsecs_next = wsecs_reg; wsub_next = wsub_reg;
        pin_we = 1'b0; slot_we = 1'b0; slot_new = 1'b0;
        slot_idx = slot_hit_reg ? hit_idx_reg : free_idx_reg;
        st = caa_pkg::ST_OK; cl = 1'b0; fwd = 1'b0; added = 1'b0;
        reply = '0; pval = '0;
        unique case (caa_pkg::op_t'(item_reg.operation))
            caa_pkg::OP_TICK: begin
                if (wsecs_reg != 0) begin
                    if (wsub_reg == 0) begin
                        wsecs_next = wsecs_reg - 1'b1;
                        wsub_next  = TPS_M1;
                    end else begin
                        wsub_next = wsub_reg - 1'b1;
                    end
                    if (wsecs_next <= 17'd1 && wsub_next == 0) begin
                        wsecs_next = '0; wsub_next = '0;
                    end
                end
            end
            caa_pkg::OP_SUBSCRIBE, caa_pkg::OP_CONTROL: begin
                if (!pin_hit_reg && (wsecs_reg == 0 || ptotal_reg >= CW'(N))) begin
                    st = caa_pkg::ST_REFUSED; cl = 1'b1;
                end else begin
                    if (!pin_hit_reg) begin
                        pin_we = 1'b1; ptotal_next = ptotal_reg + 1'b1; added = 1'b1;
                        wsecs_next = '0; wsub_next = '0;
                    end
                    if (!slot_hit_reg && !free_found_reg) begin
                        st = caa_pkg::ST_NO_SLOT;
                    end else begin
                        slot_we = 1'b1;
                        slot_new = !slot_hit_reg;
                        used_next[slot_idx] = 1'b1;
                        if (slot_new) sub_next[slot_idx] = 1'b0;
                        reply = 4'(slot_idx);
                        if (item_reg.operation == caa_pkg::OP_SUBSCRIBE) begin
                            if (item_reg.write_length < 8'd2) begin
                                st = caa_pkg::ST_SHORT;
                            end else begin
                                sub_next[slot_idx] = item_reg.subscribe_word != 0;
                                if (sub_next[slot_idx] && !drv_valid_reg) begin
                                    drv_valid_next = 1'b1; drv_slot_next = slot_idx;
                                    epoch_next = epoch_reg + 1'b1;
                                end
                            end
                        end else begin
                            if (!(drv_valid_reg && drv_slot_reg == slot_idx)) begin
                                drv_valid_next = 1'b1; drv_slot_next = slot_idx;
                                epoch_next = epoch_reg + 1'b1;
                            end
                            fwd = item_reg.write_length != 0;
                        end
                    end
                end
            end
            caa_pkg::OP_DISCONN: begin
                if (slot_hit_reg) begin
                    used_next[hit_idx_reg] = 1'b0; sub_next[hit_idx_reg] = 1'b0;
                    if (drv_valid_reg && drv_slot_reg == hit_idx_reg) begin
                        drv_valid_next = 1'b0; drv_slot_next = '0;
                        epoch_next = epoch_reg + 1'b1;
                    end
                end
            end
            caa_pkg::OP_OPEN: begin
                wsecs_next = (item_reg.window_seconds == 0) ? 17'd0
                             : 17'(item_reg.window_seconds) + 17'd1;
                wsub_next = '0;
            end
            caa_pkg::OP_CLOSE: begin
                wsecs_next = '0; wsub_next = '0;
            end
            caa_pkg::OP_FORGET: begin
                ptotal_next = '0; wsecs_next = '0; wsub_next = '0;
                used_next = '0; sub_next = '0; drv_valid_next = 1'b0;
                drv_slot_next = '0; epoch_next = epoch_reg + 1'b1; added = 1'b1;
            end
            caa_pkg::OP_READ_PIN: begin
                if (5'(item_reg.pin_index) < 5'(ptotal_reg))
                    pval = pin_tab[item_reg.pin_index[IW-1:0]];
                else
                    st = caa_pkg::ST_BAD_INDEX;
            end
            default: ;
        endcase
    end

    // table writes
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            if (pin_we) pin_tab[ptotal_reg[IW-1:0]] <= item_reg.peer_address;
            if (slot_we) begin
                slot_link[slot_idx] <= item_reg.link_id;
                if (slot_new) slot_addr[slot_idx] <= item_reg.peer_address;
            end
        end
    end

    // control state and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0; sub_reg <= '0; ptotal_reg <= '0; drv_slot_reg <= '0;
            drv_valid_reg <= 1'b0; epoch_reg <= '0; wsecs_reg <= '0; wsub_reg <= '0;
        end else if (cmd.execute) begin
            used_reg <= used_next; sub_reg <= sub_next; ptotal_reg <= ptotal_next;
            drv_slot_reg <= drv_slot_next; drv_valid_reg <= drv_valid_next;
            epoch_reg <= epoch_next; wsecs_reg <= wsecs_next; wsub_reg <= wsub_next;
            out_reg.status          <= st;
            out_reg.close_link      <= cl;
            out_reg.forward_payload <= fwd;
            out_reg.reply_slot      <= reply;
            out_reg.driver_valid    <= drv_valid_next;
            out_reg.driver_slot     <= drv_valid_next ? 4'(drv_slot_next) : 4'd0;
            out_reg.driver_ready    <= drv_valid_next && used_next[drv_slot_next]
                                       && sub_next[drv_slot_next];
            out_reg.driver_epoch    <= epoch_next;
            out_reg.pinned_count    <= 5'(ptotal_next);
            out_reg.window_left     <= wsecs_next;
            out_reg.pin_added       <= added;
            out_reg.pin_value       <= pval;
        end
    end

`ifndef NO_ASSERTIONS
    a_ptotal: assert property (@(posedge aclk) disable iff (!aresetn)
        ptotal_reg <= CW'(N)) else $error("pinned count overflow");
    a_sub_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (sub_reg & ~used_reg) == '0) else $error("subscribed slot not in use");
    a_drv: assert property (@(posedge aclk) disable iff (!aresetn)
        drv_valid_reg |-> used_reg[drv_slot_reg]) else $error("driver slot unused");
`endif
endmodule

/* rtl/caa_ctrl.sv */
// caa_ctrl: sequencer for load, scan, execute and result handshake
// depends on caa_pkg
`timescale 1ns / 1ps
module caa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output caa_pkg::cmd_t  cmd,
    input  caa_pkg::stat_t stat
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;

    // a new item is taken in idle once the result register is free or emptying
    assign s_ready = (state_reg == S_IDLE) && (!mv_reg || m_ready);
    assign m_valid = mv_reg;
    assign cmd.load    = s_valid && s_ready;
    assign cmd.scan    = (state_reg == S_SCAN);
    assign cmd.execute = (state_reg == S_EXEC);

    always_comb begin
        state_next = state_reg;
        mv_next = mv_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: if (cmd.load) state_next = S_SCAN;
            S_SCAN: if (stat.scan_last) state_next = S_EXEC;
            S_EXEC: begin
                state_next = S_IDLE;
                mv_next = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_exec_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> !mv_reg) else $error("result overwritten");
    a_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |=> m_valid) else $error("result not shown");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == S_SCAN)) else $error("load not followed by scan");
`endif
endmodule

/* sim/caa_checker.sv */
// caa_checker: watches both channels of the controller authorisation arbiter,
// predicts each result from the accepted items and compares field by field
// depends on caa_pkg
`timescale 1ns / 1ps
module caa_checker #(
    parameter int MAX_CONTROLLERS  = caa_pkg::MAX_CONTROLLERS_DEF,
    parameter int TICKS_PER_SECOND = caa_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  caa_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  caa_pkg::out_item_t m_item,
    output int                 fail_count,
    output int                 pending_count
);
    // predicted copy of the arbiter state
    logic [47:0] pins [MAX_CONTROLLERS];
    int          pin_total;
    logic        used [MAX_CONTROLLERS];
    logic        subscribed [MAX_CONTROLLERS];
    logic [15:0] links [MAX_CONTROLLERS];
    logic [47:0] addrs [MAX_CONTROLLERS];
    int          drv_slot;
    logic        drv_valid;
    logic [31:0] epoch;
    int          win_secs;
    int          win_sub;

    caa_pkg::out_item_t expected_results [$];

    function automatic void clear_state();
        for (int i = 0; i < MAX_CONTROLLERS; i++) begin
            pins[i] = '0;
            used[i] = 1'b0;
            subscribed[i] = 1'b0;
            links[i] = '0;
            addrs[i] = '0;
        end
        pin_total = 0;
        drv_slot = 0;
        drv_valid = 1'b0;
        win_secs = 0;
        win_sub = 0;
    endfunction

    function automatic void claim_drive(input int slot);
        if (!(drv_valid && drv_slot == slot)) begin
            drv_slot = slot;
            drv_valid = 1'b1;
            epoch = epoch + 1;
        end
    endfunction

    // work out the result of one accepted item and update the predicted state
    function automatic caa_pkg::out_item_t arbitrate(input caa_pkg::in_item_t it);
        caa_pkg::out_item_t r;
        logic allowed;
        logic known;
        int slot;
        r = '0;
        case (caa_pkg::op_t'(it.operation))
            caa_pkg::OP_TICK: begin
                if (win_secs != 0) begin
                    if (win_sub == 0) begin
                        win_secs--;
                        win_sub = TICKS_PER_SECOND - 1;
                    end else begin
                        win_sub--;
                    end
                    if (win_secs <= 1 && win_sub == 0) begin
                        win_secs = 0;
                        win_sub = 0;
                    end
                end
            end
            caa_pkg::OP_SUBSCRIBE, caa_pkg::OP_CONTROL: begin
                known = 1'b0;
                for (int i = 0; i < pin_total; i++)
                    if (pins[i] == it.peer_address) known = 1'b1;
                allowed = known;
                if (!known && win_secs != 0 && pin_total < MAX_CONTROLLERS) begin
                    pins[pin_total] = it.peer_address;
                    pin_total++;
                    r.pin_added = 1'b1;
                    win_secs = 0;
                    win_sub = 0;
                    allowed = 1'b1;
                end
                if (!allowed) begin
                    r.status = caa_pkg::ST_REFUSED;
                    r.close_link = 1'b1;
                end else begin
                    slot = -1;
                    for (int i = 0; i < MAX_CONTROLLERS; i++)
                        if (slot < 0 && used[i] && addrs[i] == it.peer_address) slot = i;
                    if (slot >= 0) begin
                        links[slot] = it.link_id;
                    end else begin
                        for (int i = 0; i < MAX_CONTROLLERS; i++)
                            if (slot < 0 && !used[i]) slot = i;
                        if (slot >= 0) begin
                            used[slot] = 1'b1;
                            subscribed[slot] = 1'b0;
                            links[slot] = it.link_id;
                            addrs[slot] = it.peer_address;
                        end
                    end
                    if (slot < 0) begin
                        r.status = caa_pkg::ST_NO_SLOT;
                    end else begin
                        r.reply_slot = slot[3:0];
                        if (caa_pkg::op_t'(it.operation) == caa_pkg::OP_SUBSCRIBE) begin
                            if (it.write_length < 2) begin
                                r.status = caa_pkg::ST_SHORT;
                            end else begin
                                subscribed[slot] = (it.subscribe_word != 0);
                                if (subscribed[slot] && !drv_valid) claim_drive(slot);
                            end
                        end else begin
                            claim_drive(slot);
                            r.forward_payload = (it.write_length > 0);
                        end
                    end
                end
            end
            caa_pkg::OP_DISCONN: begin
                slot = -1;
                for (int i = 0; i < MAX_CONTROLLERS; i++)
                    if (slot < 0 && used[i] && addrs[i] == it.peer_address) slot = i;
                if (slot >= 0) begin
                    used[slot] = 1'b0;
                    subscribed[slot] = 1'b0;
                    if (drv_valid && drv_slot == slot) begin
                        drv_valid = 1'b0;
                        drv_slot = 0;
                        epoch = epoch + 1;
                    end
                end
            end
            caa_pkg::OP_OPEN: begin
                win_secs = (it.window_seconds == 0) ? 0 : int'(it.window_seconds) + 1;
                win_sub = 0;
            end
            caa_pkg::OP_CLOSE: begin
                win_secs = 0;
                win_sub = 0;
            end
            caa_pkg::OP_FORGET: begin
                clear_state();
                epoch = epoch + 1;
                r.pin_added = 1'b1;
            end
            default: begin
                if (it.pin_index < pin_total) r.pin_value = pins[it.pin_index];
                else r.status = caa_pkg::ST_BAD_INDEX;
            end
        endcase
        r.driver_valid = drv_valid;
        r.driver_slot = drv_valid ? drv_slot[3:0] : 4'd0;
        r.driver_ready = drv_valid && used[drv_slot] && subscribed[drv_slot];
        r.driver_epoch = epoch;
        r.pinned_count = pin_total[4:0];
        r.window_left = win_secs[16:0];
        return r;
    endfunction

    task automatic report(input string name, input logic [63:0] want, input logic [63:0] got);
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
        fail_count++;
    endtask

    // compare one result with the oldest prediction
    task automatic compare_result(input caa_pkg::out_item_t got);
        caa_pkg::out_item_t want;
        if (expected_results.size() == 0) begin
            $display("%0t unexpected result: expected none actual %h", $time, got);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (got.status != want.status) report("status", want.status, got.status);
            if (got.close_link != want.close_link)
                report("close_link", want.close_link, got.close_link);
            if (got.forward_payload != want.forward_payload)
                report("forward_payload", want.forward_payload, got.forward_payload);
            if (got.reply_slot != want.reply_slot)
                report("reply_slot", want.reply_slot, got.reply_slot);
            if (got.driver_valid != want.driver_valid)
                report("driver_valid", want.driver_valid, got.driver_valid);
            if (got.driver_slot != want.driver_slot)
                report("driver_slot", want.driver_slot, got.driver_slot);
            if (got.driver_ready != want.driver_ready)
                report("driver_ready", want.driver_ready, got.driver_ready);
            if (got.driver_epoch != want.driver_epoch)
                report("driver_epoch", want.driver_epoch, got.driver_epoch);
            if (got.pinned_count != want.pinned_count)
                report("pinned_count", want.pinned_count, got.pinned_count);
            if (got.window_left != want.window_left)
                report("window_left", want.window_left, got.window_left);
            if (got.pin_added != want.pin_added)
                report("pin_added", want.pin_added, got.pin_added);
            if (got.pin_value != want.pin_value)
                report("pin_value", want.pin_value, got.pin_value);
        end
    endtask

    initial begin
        fail_count = 0;
        pending_count = 0;
        epoch = '0;
        clear_state();
    end

    // sample both channels at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            epoch = '0;
        end else begin
            if (m_valid && m_ready) compare_result(m_item);
            if (s_valid && s_ready) expected_results.push_back(arbitrate(s_item));
        end
        pending_count = expected_results.size();
    end
endmodule

/* sim/tb_controller_authorisation_arbiter.sv */
// tb_controller_authorisation_arbiter: stimulus and verdict for the arbiter
// depends on caa_pkg, controller_authorisation_arbiter, caa_checker
// directed items first, then random peer traffic against a small address pool
`timescale 1ns / 1ps
module tb_controller_authorisation_arbiter;
    localparam int RANDOM_ITEMS = 1430;
    localparam int CYCLE_LIMIT  = 400000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    caa_pkg::in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    caa_pkg::out_item_t m_item;
    int        fail_count;
    int        pending_count;
    int        cycle_count = 0;
    logic      calm = 1'b0;
    logic [47:0] peer_pool [6];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    controller_authorisation_arbiter DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    caa_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stall bursts, none once calm
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge aclk);
        end
    end

    // hand one item over and wait for it to be taken; valid drops only for idling
    task automatic send_item(input caa_pkg::in_item_t it);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk iff s_ready);
    endtask

    function automatic caa_pkg::in_item_t make_item(input caa_pkg::op_t op,
                                                    input logic [47:0] addr);
        caa_pkg::in_item_t it;
        it.operation = op;
        it.peer_address = addr;
        it.link_id = 16'($urandom);
        it.subscribe_word = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
        it.write_length = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 1))
                                                      : 8'($urandom_range(2, 244));
        it.window_seconds = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
        it.pin_index = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4));
        return it;
    endfunction

    initial begin
        caa_pkg::in_item_t it;
        int pick;
        for (int i = 0; i < 6; i++) peer_pool[i] = 48'({$urandom, $urandom});
        peer_pool[0] = '0;
        peer_pool[1] = '1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: refusal, pairing, full table, shorts, reads, disconnects, close, forget
        it = make_item(caa_pkg::OP_SUBSCRIBE, peer_pool[0]); send_item(it);
        it = make_item(caa_pkg::OP_READ_PIN, '0); it.pin_index = 4'd0; send_item(it);
        it = make_item(caa_pkg::OP_OPEN, '0); it.window_seconds = 16'd0; send_item(it);
        it = make_item(caa_pkg::OP_OPEN, '0); it.window_seconds = 16'hffff; send_item(it);
        it = make_item(caa_pkg::OP_TICK, '0); send_item(it);
        it = make_item(caa_pkg::OP_CONTROL, peer_pool[1]); it.write_length = 8'd0;
        it.link_id = 16'hffff; send_item(it);
        it = make_item(caa_pkg::OP_OPEN, '0); it.window_seconds = 16'd1; send_item(it);
        it = make_item(caa_pkg::OP_SUBSCRIBE, peer_pool[0]); it.write_length = 8'd1;
        send_item(it);
        it = make_item(caa_pkg::OP_SUBSCRIBE, peer_pool[0]); it.write_length = 8'd244;
        it.subscribe_word = 16'hffff; send_item(it);
        for (int i = 2; i < 6; i++) begin
            it = make_item(caa_pkg::OP_OPEN, '0); it.window_seconds = 16'd1; send_item(it);
            it = make_item(caa_pkg::OP_CONTROL, peer_pool[i]); it.write_length = 8'd244;
            send_item(it);
        end
        it = make_item(caa_pkg::OP_READ_PIN, '0); it.pin_index = 4'd3; send_item(it);
        it = make_item(caa_pkg::OP_READ_PIN, '0); it.pin_index = 4'hf; send_item(it);
        it = make_item(caa_pkg::OP_DISCONN, peer_pool[1]); send_item(it);
        it = make_item(caa_pkg::OP_DISCONN, 48'h123456789abc); send_item(it);
        it = make_item(caa_pkg::OP_CLOSE, '0); send_item(it);
        it = make_item(caa_pkg::OP_FORGET, '0); send_item(it);

        // random: mostly pool peers, with window open/tick/close traffic
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k > RANDOM_ITEMS - 150) calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 30)
                it = make_item(caa_pkg::OP_SUBSCRIBE, peer_pool[$urandom_range(0, 5)]);
            else if (pick < 52)
                it = make_item(caa_pkg::OP_CONTROL, peer_pool[$urandom_range(0, 5)]);
            else if (pick < 62)
                it = make_item(caa_pkg::OP_DISCONN, peer_pool[$urandom_range(0, 5)]);
            else if (pick < 72) it = make_item(caa_pkg::OP_OPEN, '0);
            else if (pick < 84) it = make_item(caa_pkg::OP_TICK, '0);
            else if (pick < 88) it = make_item(caa_pkg::OP_CLOSE, '0);
            else if (pick < 90) it = make_item(caa_pkg::OP_FORGET, '0);
            else if (pick < 96) it = make_item(caa_pkg::OP_READ_PIN, '0);
            else it = make_item(caa_pkg::op_t'($urandom_range(0, 7)),
                                48'({$urandom, $urandom}));
            send_item(it);
        end
        s_valid <= 1'b0;

        @(posedge aclk iff pending_count == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/caa_pkg.sv
rtl/caa_datapath.sv
rtl/caa_ctrl.sv
rtl/controller_authorisation_arbiter.sv
sim/caa_checker.sv
sim/tb_controller_authorisation_arbiter.sv
